FILE: src/tpi_pkg.sv
// shared types, constants and force table for the thrust to pwm interpolator
`default_nettype none
package tpi_pkg;

  localparam int unsigned CHANNELS     = 4;
  localparam int unsigned FORCE_STORED = 30;
  localparam int unsigned IDX_W        = 7;
  localparam int unsigned FORCE_W      = 24;
  localparam int unsigned DUTY_W       = 14;
  localparam int unsigned CMP_W        = 13;
  localparam int unsigned THRUST_W     = 16;
  localparam int unsigned AR_W         = 16;
  localparam int unsigned DUTY_BASE    = 6000;
  localparam int unsigned DUTY_STEP    = 100;
  localparam int unsigned DUTY_FALLBACK = 7500;
  localparam int unsigned THRUST_SCALE = 102;
  localparam int unsigned CMP_DIVISOR  = 100000;
  localparam int unsigned AR_RESET     = 19999;

  localparam logic signed [11:0] ForceGrams [FORCE_STORED] = '{
    -12'sd780, -12'sd689, -12'sd605, -12'sd510, -12'sd440,
    -12'sd354, -12'sd290, -12'sd225, -12'sd174, -12'sd118,
    -12'sd70,  -12'sd42,  -12'sd16,  -12'sd2,   12'sd0,
    12'sd0,    12'sd0,    12'sd5,    12'sd33,   12'sd84,
    12'sd154,  12'sd238,  12'sd333,  12'sd448,  12'sd569,
    12'sd700,  12'sd826,  12'sd982,  12'sd1100, 12'sd1250
  };

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] duty;
    logic [CMP_W-1:0]  cmp;
  } lane_status_t;

  // force point in 1/256 gram, last stored point repeats
  function automatic logic signed [FORCE_W-1:0] force_point(input logic [IDX_W-1:0] i);
    logic [4:0]         k;
    logic signed [11:0] g;
    k = (i < IDX_W'(FORCE_STORED)) ? i[4:0] : 5'(FORCE_STORED - 1);
    g = ForceGrams[k];
    return {{(FORCE_W-20){g[11]}}, g, 8'b0};
  endfunction

  function automatic logic [DUTY_W-1:0] duty_point(input logic [IDX_W-1:0] i);
    return DUTY_W'(DUTY_BASE) + DUTY_W'(i) * DUTY_W'(DUTY_STEP);
  endfunction

endpackage
`default_nettype wire

FILE: src/tpi_lane.sv
// one channel: segment search, interpolation divider and compare scaling
`default_nettype none
module tpi_lane #(
  parameter int unsigned TABLE_POINTS = 30
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [tpi_pkg::THRUST_W-1:0] thrust_i,
  input  wire logic [tpi_pkg::AR_W-1:0]            auto_reload_i,
  output tpi_pkg::lane_status_t                    status_o
);

  localparam int unsigned IW = tpi_pkg::IDX_W;
  localparam int unsigned DW = tpi_pkg::DUTY_W;
  localparam int unsigned FW = tpi_pkg::FORCE_W;
  localparam int unsigned RW = 31;
  localparam int unsigned QW = tpi_pkg::CMP_W;
  localparam logic [IW-1:0] Last = IW'(TABLE_POINTS - 1);
  // product / 100000 as (product >> 5) / 3125 by reciprocal multiplication
  localparam int unsigned RecipShift = 37;
  localparam logic [25:0] RecipMul   = 26'd43980466;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SEARCH, S_DIV, S_MUL, S_CDIV, S_DONE
  } state_e;

  state_e              state_q;
  logic signed [FW-1:0] force_q;
  logic [IW-1:0]       idx_q;
  logic [DW-1:0]       duty_q;
  logic [RW-1:0]       rem_q;
  logic [RW-1:0]       dsr_q;
  logic [QW-1:0]       quo_q;
  logic [3:0]          cnt_q;
  logic [QW-1:0]       cmp_q;

  logic signed [FW-1:0] f1, f2, off;
  logic [DW-1:0]        top, duty_c;
  logic                 ge;
  logic [50:0]          recip_prod;

  assign f1  = tpi_pkg::force_point(idx_q);
  assign f2  = tpi_pkg::force_point(idx_q + IW'(1));
  assign off = force_q - f1;
  assign top = tpi_pkg::duty_point(Last);
  assign ge  = rem_q >= dsr_q;
  assign duty_c = (duty_q < DW'(tpi_pkg::DUTY_BASE)) ? DW'(tpi_pkg::DUTY_BASE) :
                  (duty_q > top) ? top : duty_q;
  assign recip_prod = 51'(rem_q[29:5]) * 51'(RecipMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      force_q <= '0;
      idx_q   <= '0;
      duty_q  <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      cmp_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE, S_DONE: begin
          if (start_i) begin
            force_q <= FW'(thrust_i) * FW'(tpi_pkg::THRUST_SCALE);
            idx_q   <= '0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (force_q <= tpi_pkg::force_point('0)) begin
            duty_q  <= tpi_pkg::duty_point('0);
            state_q <= S_MUL;
          end else if (force_q >= tpi_pkg::force_point(Last)) begin
            duty_q  <= top;
            state_q <= S_MUL;
          end else begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (force_q >= f1 && force_q <= f2) begin
            duty_q <= tpi_pkg::duty_point(idx_q);
            if (f1 == f2) begin
              state_q <= S_MUL;
            end else begin
              rem_q   <= RW'(off) * RW'(tpi_pkg::DUTY_STEP);
              dsr_q   <= RW'(f2 - f1) << 6;
              quo_q   <= '0;
              cnt_q   <= 4'd6;
              state_q <= S_DIV;
            end
          end else if (idx_q + IW'(1) >= Last) begin
            duty_q  <= DW'(tpi_pkg::DUTY_FALLBACK);
            state_q <= S_MUL;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_DIV: begin
          if (ge) rem_q <= rem_q - dsr_q;
          dsr_q <= dsr_q >> 1;
          quo_q <= {quo_q[QW-2:0], ge};
          if (cnt_q == '0) begin
            duty_q  <= duty_q + DW'({quo_q[QW-2:0], ge});
            state_q <= S_MUL;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_MUL: begin
          duty_q  <= duty_c;
          rem_q   <= RW'(duty_c) * RW'({1'b0, auto_reload_i} + 17'd1);
          state_q <= S_CDIV;
        end
        S_CDIV: begin
          cmp_q   <= QW'(recip_prod >> RecipShift);
          state_q <= S_DONE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o.done = (state_q == S_DONE);
  assign status_o.duty = duty_q;
  assign status_o.cmp  = cmp_q;

endmodule
`default_nettype wire

FILE: src/thrust_to_pwm_interpolator.sv
// top level: four channel lanes, merge of their results, reload register
// a request runs the check, the compare multiply and the compare scaling when the force is clamped
// to a table end; otherwise a serial segment search and, unless the segment is flat, the 7-step
// interpolation divider run between the check and the compare multiply
// one request at a time; busy_o drops with the result strobe
// results are strobed for one cycle on result_valid_o; the receiver cannot stall
// async active-low reset clears control state and sets auto_reload to 19999
`default_nettype none
module thrust_to_pwm_interpolator #(
  parameter int unsigned TABLE_POINTS = 30
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [tpi_pkg::AR_W-1:0]            cfg_wdata_i,
  input  wire logic signed [tpi_pkg::THRUST_W-1:0] thrust_0_i,
  input  wire logic signed [tpi_pkg::THRUST_W-1:0] thrust_1_i,
  input  wire logic signed [tpi_pkg::THRUST_W-1:0] thrust_2_i,
  input  wire logic signed [tpi_pkg::THRUST_W-1:0] thrust_3_i,
  output logic                                     result_valid_o,
  output logic [tpi_pkg::DUTY_W-1:0]               duty_0_o,
  output logic [tpi_pkg::DUTY_W-1:0]               duty_1_o,
  output logic [tpi_pkg::DUTY_W-1:0]               duty_2_o,
  output logic [tpi_pkg::DUTY_W-1:0]               duty_3_o,
  output logic [tpi_pkg::CMP_W-1:0]                compare_0_o,
  output logic [tpi_pkg::CMP_W-1:0]                compare_1_o,
  output logic [tpi_pkg::CMP_W-1:0]                compare_2_o,
  output logic [tpi_pkg::CMP_W-1:0]                compare_3_o
);

  localparam int unsigned NC = tpi_pkg::CHANNELS;

  typedef enum logic {T_IDLE, T_RUN} state_e;

  state_e                           state_q;
  logic                             valid_q;
  logic [tpi_pkg::AR_W-1:0]         ar_q;
  logic [tpi_pkg::DUTY_W-1:0]       duty_q [NC];
  logic [tpi_pkg::CMP_W-1:0]        cmp_q  [NC];
  logic signed [tpi_pkg::THRUST_W-1:0] thrust [NC];
  tpi_pkg::lane_status_t            status [NC];
  logic [NC-1:0]                    done;
  logic                             go;

  assign thrust[0] = thrust_0_i;
  assign thrust[1] = thrust_1_i;
  assign thrust[2] = thrust_2_i;
  assign thrust[3] = thrust_3_i;
  assign go = start_i && (state_q == T_IDLE);

  for (genvar c = 0; c < NC; c++) begin : g_lane
    tpi_lane #(.TABLE_POINTS(TABLE_POINTS)) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .start_i       (go),
      .thrust_i      (thrust[c]),
      .auto_reload_i (ar_q),
      .status_o      (status[c])
    );
    assign done[c] = status[c].done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ar_q <= tpi_pkg::AR_W'(tpi_pkg::AR_RESET);
    end else if (cfg_we_i) begin
      ar_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        T_IDLE: if (go) state_q <= T_RUN;
        T_RUN: begin
          if (&done) begin
            valid_q <= 1'b1;
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  // merge: capture all lanes together
  always_ff @(posedge clk_i) begin
    if (state_q == T_RUN && (&done)) begin
      for (int c = 0; c < NC; c++) begin
        duty_q[c] <= status[c].duty;
        cmp_q[c]  <= status[c].cmp;
      end
    end
  end

  assign busy_o         = (state_q != T_IDLE);
  assign result_valid_o = valid_q;
  assign duty_0_o       = duty_q[0];
  assign duty_1_o       = duty_q[1];
  assign duty_2_o       = duty_q[2];
  assign duty_3_o       = duty_q[3];
  assign compare_0_o    = cmp_q[0];
  assign compare_1_o    = cmp_q[1];
  assign compare_2_o    = cmp_q[2];
  assign compare_3_o    = cmp_q[3];

endmodule
`default_nettype wire
